// ----- src/srqe_pkg.sv -----
// ----------------------------------------------------------------------------
// srqe_pkg: shared types, codes and helpers for the self-relative queue engine
// Holds the sizing constants, the microcode control word, the program ROM and
// the link arithmetic used by the datapath.
// ----------------------------------------------------------------------------
package srqe_pkg;

	// Link store sizing. SLOTS must be a power of two.
	localparam int SLOTS  = 1024;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ADDR_W = 13;
	localparam int LINK_W = 14;
	localparam int STEP_W = 4;

	typedef enum logic [1:0] {
		OP_INS_HEAD = 2'd0,
		OP_INS_TAIL = 2'd1,
		OP_REM_HEAD = 2'd2,
		OP_REM_TAIL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_ONE    = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	typedef enum logic {
		RD_HDR = 1'b0,
		RD_X   = 1'b1
	} rd_sel_t;

	// Link write patterns, P = primary direction, S = secondary direction
	typedef enum logic [1:0] {
		WR_NONE   = 2'd0,
		WR_ENT    = 2'd1,  // P[ent] = x-ent,   S[ent] = hdr-ent
		WR_LINK   = 2'd2,  // P[hdr] = ent-hdr, S[x]   = ent-x
		WR_UNLINK = 2'd3   // P[hdr] = y-hdr,   S[y]   = hdr-y
	} wr_t;

	typedef enum logic [2:0] {
		JC_NONE   = 3'd0,
		JC_ALWAYS = 3'd1,
		JC_BAD    = 3'd2,
		JC_REMOVE = 3'd3,
		JC_EMPTY  = 3'd4
	} jc_t;

	// Program steps
	localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] S_RDH  = 4'd1;
	localparam logic [STEP_W-1:0] S_LDX  = 4'd2;
	localparam logic [STEP_W-1:0] S_WENT = 4'd3;
	localparam logic [STEP_W-1:0] S_WLNK = 4'd4;
	localparam logic [STEP_W-1:0] S_RDX  = 4'd5;
	localparam logic [STEP_W-1:0] S_LDY  = 4'd6;
	localparam logic [STEP_W-1:0] S_WUNL = 4'd7;
	localparam logic [STEP_W-1:0] S_DONE = 4'd8;

	typedef struct packed {
		logic              wait_in;
		logic              emit;
		logic              rd_en;
		rd_sel_t           rd_sel;
		logic              ld_x;
		logic              ld_y;
		wr_t               wr;
		jc_t               jc;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic bad;
		logic remove;
		logic empty;
	} flags_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} wr_req_t;

	// Microcode ROM
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
		ctrl_t w;
		w = '0;
		case (pc)
			S_IDLE: begin
				w.wait_in = 1'b1;
			end
			S_RDH: begin
				w.rd_en  = 1'b1;
				w.rd_sel = RD_HDR;
				w.jc     = JC_BAD;
				w.target = S_DONE;
			end
			S_LDX: begin
				w.ld_x   = 1'b1;
				w.jc     = JC_REMOVE;
				w.target = S_RDX;
			end
			S_WENT: begin
				w.wr = WR_ENT;
			end
			S_WLNK: begin
				w.wr     = WR_LINK;
				w.jc     = JC_ALWAYS;
				w.target = S_DONE;
			end
			S_RDX: begin
				w.rd_en  = 1'b1;
				w.rd_sel = RD_X;
				w.jc     = JC_EMPTY;
				w.target = S_DONE;
			end
			S_LDY: begin
				w.ld_y = 1'b1;
			end
			S_WUNL: begin
				w.wr = WR_UNLINK;
			end
			S_DONE: begin
				w.emit   = 1'b1;
				w.jc     = JC_ALWAYS;
				w.target = S_IDLE;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

	// Byte address to slot index: drops the low three bits, so the address space covers the slots exactly
	function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] a);
		logic [SLOT_W+ADDR_W-4:0] ext;
		ext = {{SLOT_W{1'b0}}, a[ADDR_W-1:3]};
		return ext[SLOT_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] follow(input logic [ADDR_W-1:0] base,
		input logic [LINK_W-1:0] disp);
		return base + disp[ADDR_W-1:0];
	endfunction

	function automatic logic [LINK_W-1:0] disp_to(input logic [ADDR_W-1:0] from,
		input logic [ADDR_W-1:0] to);
		return {1'b0, to} - {1'b0, from};
	endfunction

	function automatic logic bad_addr(input logic [ADDR_W-1:0] a);
		return (a == '0) || (a[2:0] != 3'd0);
	endfunction

endpackage

// ----- src/srqe_ram.sv -----
// ----------------------------------------------------------------------------
// srqe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srqe_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/srqe_seq.sv -----
// ----------------------------------------------------------------------------
// srqe_seq: microcode sequencer
// Step counter over the program ROM, with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module srqe_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           out_free,
	input  srqe_pkg::flags_t               flags,
	output srqe_pkg::ctrl_t                ctrl,
	output logic [srqe_pkg::STEP_W-1:0]    pc
);

	logic [srqe_pkg::STEP_W-1:0] pc_q;
	logic [srqe_pkg::STEP_W-1:0] pc_d;
	logic                        adv;
	logic                        take;

	assign ctrl = srqe_pkg::ucode(pc_q);

	always_comb begin
		case (ctrl.jc)
			srqe_pkg::JC_NONE:   take = 1'b0;
			srqe_pkg::JC_ALWAYS: take = 1'b1;
			srqe_pkg::JC_BAD:    take = flags.bad;
			srqe_pkg::JC_REMOVE: take = flags.remove;
			srqe_pkg::JC_EMPTY:  take = flags.empty;
			default:             take = 1'b0;
		endcase
	end

	// hold on idle until a word arrives, and on emit until the output frees
	assign adv  = ctrl.wait_in ? start : (ctrl.emit ? out_free : 1'b1);
	assign pc_d = take ? ctrl.target : pc_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= srqe_pkg::S_IDLE;
		end else if (adv) begin
			pc_q <= pc_d;
		end
	end

	assign pc = pc_q;

endmodule

// ----- src/srqe_dp.sv -----
// ----------------------------------------------------------------------------
// srqe_dp: operand registers and link arithmetic
// Holds the operation, follows links read from the store and forms the link
// writes for each microcode step.
// ----------------------------------------------------------------------------
module srqe_dp (
	input  logic                          clk,
	input  srqe_pkg::ctrl_t               ctrl,
	input  logic                          load,
	input  logic [1:0]                    in_opcode,
	input  logic [srqe_pkg::ADDR_W-1:0]   in_entry,
	input  logic [srqe_pkg::ADDR_W-1:0]   in_header,
	input  logic [srqe_pkg::LINK_W-1:0]   f_rdata,
	input  logic [srqe_pkg::LINK_W-1:0]   b_rdata,
	output logic                          rd_en,
	output logic [srqe_pkg::SLOT_W-1:0]   rd_addr,
	output srqe_pkg::wr_req_t             f_wr,
	output srqe_pkg::wr_req_t             b_wr,
	output srqe_pkg::flags_t              flags,
	output logic [1:0]                    status,
	output logic [srqe_pkg::ADDR_W-1:0]   removed_addr
);

	logic [1:0]                  op_q;
	logic [srqe_pkg::ADDR_W-1:0] ent_q;
	logic [srqe_pkg::ADDR_W-1:0] hdr_q;
	logic [srqe_pkg::ADDR_W-1:0] x_q;
	logic [srqe_pkg::ADDR_W-1:0] y_q;
	logic                        bad_q;
	logic                        empty_q;

	logic                        tail;
	logic                        remove;
	logic [srqe_pkg::LINK_W-1:0] prd;
	srqe_pkg::wr_req_t           p_wr;
	srqe_pkg::wr_req_t           s_wr;
	srqe_pkg::status_t           st;

	// tail operations walk the backward links as their primary direction
	assign tail   = op_q[0];
	assign remove = op_q[1];
	assign prd    = tail ? b_rdata : f_rdata;

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= in_opcode;
			ent_q <= in_entry;
			hdr_q <= in_header;
			bad_q <= srqe_pkg::bad_addr(in_header)
				|| (!in_opcode[1] && srqe_pkg::bad_addr(in_entry));
		end
		if (ctrl.ld_x) begin
			x_q     <= srqe_pkg::follow(hdr_q, prd);
			empty_q <= (prd == '0);
		end
		if (ctrl.ld_y) begin
			y_q <= srqe_pkg::follow(x_q, prd);
		end
	end

	assign rd_en   = ctrl.rd_en;
	assign rd_addr = srqe_pkg::slot_of((ctrl.rd_sel == srqe_pkg::RD_HDR) ? hdr_q : x_q);

	always_comb begin
		p_wr = '0;
		s_wr = '0;
		case (ctrl.wr)
			srqe_pkg::WR_ENT: begin
				p_wr = '{1'b1, srqe_pkg::slot_of(ent_q), srqe_pkg::disp_to(ent_q, x_q)};
				s_wr = '{1'b1, srqe_pkg::slot_of(ent_q), srqe_pkg::disp_to(ent_q, hdr_q)};
			end
			srqe_pkg::WR_LINK: begin
				p_wr = '{1'b1, srqe_pkg::slot_of(hdr_q), srqe_pkg::disp_to(hdr_q, ent_q)};
				s_wr = '{1'b1, srqe_pkg::slot_of(x_q), srqe_pkg::disp_to(x_q, ent_q)};
			end
			srqe_pkg::WR_UNLINK: begin
				p_wr = '{1'b1, srqe_pkg::slot_of(hdr_q), srqe_pkg::disp_to(hdr_q, y_q)};
				s_wr = '{1'b1, srqe_pkg::slot_of(y_q), srqe_pkg::disp_to(y_q, hdr_q)};
			end
			default: begin
				p_wr = '0;
				s_wr = '0;
			end
		endcase
	end

	assign f_wr = tail ? s_wr : p_wr;
	assign b_wr = tail ? p_wr : s_wr;

	assign flags = '{bad: bad_q, remove: remove, empty: empty_q};

	always_comb begin
		if (bad_q) begin
			st = srqe_pkg::ST_BAD;
		end else if (remove && empty_q) begin
			st = srqe_pkg::ST_EMPTY;
		end else if (remove) begin
			st = (y_q == hdr_q) ? srqe_pkg::ST_ONE : srqe_pkg::ST_NORMAL;
		end else begin
			st = (x_q == hdr_q) ? srqe_pkg::ST_ONE : srqe_pkg::ST_NORMAL;
		end
	end

	assign status       = st;
	assign removed_addr = (remove && !bad_q && !empty_q) ? x_q : '0;

endmodule

// ----- src/self_relative_queue_engine_core.sv -----
// ----------------------------------------------------------------------------
// self_relative_queue_engine_core: self-relative queue insert/remove engine
// Keeps doubly linked circular queues of self-relative links in an on-chip
// link store and runs insert/remove operations on them from a microprogram.
// ----------------------------------------------------------------------------
// One word in, one word out per operation, handled one at a time. The
// microprogram reads the link store before its writes: a remove does two
// dependent reads, an insert one, and each RAM has a single write port. After
// reset the block first clears the whole link store, one slot per cycle:
// tready stays low until every slot has been cleared. A result can wait in the
// output register while the next word is accepted; the program stalls at its
// final step only when the previous result has not yet been taken.
module self_relative_queue_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // opcode[1:0], entry_addr[14:2], header_addr[27:15]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // status[1:0], removed_addr[14:2]
);

	srqe_pkg::ctrl_t             ctrl;
	srqe_pkg::flags_t            flags;
	srqe_pkg::wr_req_t           f_wr;
	srqe_pkg::wr_req_t           b_wr;
	logic [srqe_pkg::STEP_W-1:0] pc;

	logic                          accept;
	logic                          out_free;
	logic                          rd_en;
	logic [srqe_pkg::SLOT_W-1:0]   rd_addr;
	logic [srqe_pkg::LINK_W-1:0]   f_rdata;
	logic [srqe_pkg::LINK_W-1:0]   b_rdata;
	logic [1:0]                    status;
	logic [srqe_pkg::ADDR_W-1:0]   removed_addr;

	// clearing pass
	logic                        clr_busy_q;
	logic [srqe_pkg::SLOT_W-1:0] clr_idx_q;

	// RAM write ports after the clear mux
	logic                        f_we;
	logic [srqe_pkg::SLOT_W-1:0] f_waddr;
	logic [srqe_pkg::LINK_W-1:0] f_wdata;
	logic                        b_we;
	logic [srqe_pkg::SLOT_W-1:0] b_waddr;
	logic [srqe_pkg::LINK_W-1:0] b_wdata;

	// output register
	logic                        m_valid_q;
	logic [1:0]                  m_status_q;
	logic [srqe_pkg::ADDR_W-1:0] m_removed_q;

	assign s_axis_tready = ctrl.wait_in && !clr_busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	srqe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.flags    (flags),
		.ctrl     (ctrl),
		.pc       (pc)
	);

	srqe_dp u_dp (
		.clk          (clk),
		.ctrl         (ctrl),
		.load         (accept),
		.in_opcode    (s_axis_tdata[1:0]),
		.in_entry     (s_axis_tdata[14:2]),
		.in_header    (s_axis_tdata[27:15]),
		.f_rdata      (f_rdata),
		.b_rdata      (b_rdata),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.f_wr         (f_wr),
		.b_wr         (b_wr),
		.flags        (flags),
		.status       (status),
		.removed_addr (removed_addr)
	);

	// Sweep every slot to zero after reset: each slot becomes an empty header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == srqe_pkg::SLOT_W'(srqe_pkg::SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign f_we    = clr_busy_q || f_wr.we;
	assign f_waddr = clr_busy_q ? clr_idx_q : f_wr.addr;
	assign f_wdata = clr_busy_q ? '0 : f_wr.data;
	assign b_we    = clr_busy_q || b_wr.we;
	assign b_waddr = clr_busy_q ? clr_idx_q : b_wr.addr;
	assign b_wdata = clr_busy_q ? '0 : b_wr.data;

	// forward links
	srqe_ram #(
		.WIDTH (srqe_pkg::LINK_W),
		.DEPTH (srqe_pkg::SLOTS)
	) u_fwd (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (f_rdata)
	);

	// backward links
	srqe_ram #(
		.WIDTH (srqe_pkg::LINK_W),
		.DEPTH (srqe_pkg::SLOTS)
	) u_bwd (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (b_rdata)
	);

	// Result word register; loaded at the final program step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			m_status_q  <= status;
			m_removed_q <= removed_addr;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_removed_q, m_status_q};

	// the sequencer must sit at idle for the whole clearing pass
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (pc == srqe_pkg::S_IDLE))
		else $error("sequencer left idle during link store clear");

	// an accepted word always starts the header read
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (pc == srqe_pkg::S_RDH))
		else $error("accepted word did not start the program");

	// a result only appears from the final program step
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(pc == srqe_pkg::S_DONE))
		else $error("result word raised outside the final step");

endmodule
